### hw/rtl/pqkr_pkg.sv
// Package for the keyed-removal priority queue.
// Holds the depth constants, the item structs and the command and status
// structs that join the controller and the datapath. No dependencies.
`default_nettype none

package pqkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_FIND = 2'd2,
    OP_REM  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DSEL_NONE,
    DSEL_BEST,
    DSEL_HIT
  } dsel_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] name_key;
    logic [31:0] book_key;
    logic [1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_name_key;
    logic [31:0] out_book_key;
    logic [1:0]  out_priority;
  } out_item_t;

  typedef struct packed {
    logic [31:0] name;
    logic [31:0] book;
    logic [1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    enq_wr;
    logic    scan;
    logic    swap_a;
    logic    swap_b;
    logic    shift_start;
    logic    shift;
    logic    tail_dec;
    logic    res_load;
    status_t res_st;
    dsel_t   res_dat;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic scan_done;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/priority_queue_with_keyed_removal_top.sv
// Top level of the keyed-removal priority queue: joins controller and datapath.
// Depends on pqkr_pkg, pqkr_ctrl and pqkr_dp.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid / in_stall  pqkr_pkg::in_item_t
//   out_*        out   out_valid / out_stall pqkr_pkg::out_item_t
//
// Enqueue, failed enqueue and empty dequeue go from decode straight to the result.
// Dequeue, find and remove read the live entries one a cycle from the entry
// memory; dequeue then swaps the best entry with the head entry, and remove
// shifts the live entries after the match down by one slot.
// Reset clears head, tail and control; entries stay unwritten.
// A new item is taken while a result still waits under out_stall.
`default_nettype none

module priority_queue_with_keyed_removal_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pqkr_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pqkr_pkg::out_item_t       out_data
);
  import pqkr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pqkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pqkr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_wr |-> !stat.full)
    else $error("enqueue write while full");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_a |=> cmd.swap_b)
    else $error("swap not completed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("not busy after transfer");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without load");
`endif

endmodule

`default_nettype wire

### hw/rtl/pqkr_dp.sv
// Datapath of the keyed-removal priority queue: entry memory, head and tail,
// scan pointer, best and hit trackers, result and output registers.
// Depends on pqkr_pkg.
`default_nettype none

module pqkr_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pqkr_pkg::in_item_t   in_data,
  input  wire pqkr_pkg::cmd_t       cmd,
  output pqkr_pkg::stat_t           stat,
  output pqkr_pkg::out_item_t       out_data
);
  import pqkr_pkg::*;

  entry_t           ent_mem_r [QUEUE_DEPTH];
  entry_t           rd_data_r;
  entry_t           best_r;
  entry_t           head_ent_r;
  entry_t           hit_ent_r;
  op_t              op_r;
  logic [31:0]      name_r;
  logic [31:0]      book_r;
  logic [1:0]       prio_r;
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] tail_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ri_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             rv_r;
  logic             best_vld_r;
  logic             hit_r;
  out_item_t        res_r;
  out_item_t        out_r;

  logic             step;
  logic             rd_en;
  logic             match;
  logic [IDX_W-1:0] shift_wa;

  assign step     = cmd.scan | cmd.shift;
  assign rd_en    = step && (ptr_r < tail_r);
  assign shift_wa = ri_r - IDX_W'(1);
  assign match    = (rd_data_r.book == book_r) &&
                    ((op_r == OP_FIND) || (rd_data_r.name == name_r));

  assign stat.op        = op_r;
  assign stat.full      = (tail_r == IDX_W'(QUEUE_DEPTH));
  assign stat.empty     = (head_r >= tail_r);
  assign stat.scan_done = (ptr_r >= tail_r) && !rv_r;
  assign stat.hit       = hit_r;
  assign out_data       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      rv_r   <= 1'b0;
    end else begin
      if (cmd.enq_wr) begin
        tail_r <= tail_r + IDX_W'(1);
      end else if (cmd.tail_dec) begin
        tail_r <= tail_r - IDX_W'(1);
      end
      if (cmd.swap_b) begin
        head_r <= head_r + IDX_W'(1);
      end
      if (cmd.load || cmd.shift_start) begin
        rv_r <= 1'b0;
      end else if (step) begin
        rv_r <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_data.operation;
      name_r     <= in_data.name_key;
      book_r     <= in_data.book_key;
      prio_r     <= in_data.priority_req;
      ptr_r      <= head_r;
      best_vld_r <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.shift_start) begin
      ptr_r <= hit_idx_r + IDX_W'(1);
    end else begin
      if (rd_en) begin
        ptr_r <= ptr_r + IDX_W'(1);
      end
      if (cmd.scan && rv_r) begin
        if (!best_vld_r || (rd_data_r.prio > best_r.prio)) begin
          best_r     <= rd_data_r;
          best_idx_r <= ri_r;
          best_vld_r <= 1'b1;
        end
        if (ri_r == head_r) begin
          head_ent_r <= rd_data_r;
        end
        if (!hit_r && match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= ri_r;
          hit_ent_r <= rd_data_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ent_mem_r[ptr_r[ADDR_W-1:0]];
      ri_r      <= ptr_r;
    end
    if (cmd.enq_wr) begin
      ent_mem_r[tail_r[ADDR_W-1:0]] <= '{name: name_r, book: book_r, prio: prio_r};
    end else if (cmd.swap_a) begin
      ent_mem_r[head_r[ADDR_W-1:0]] <= best_r;
    end else if (cmd.swap_b) begin
      ent_mem_r[best_idx_r[ADDR_W-1:0]] <= head_ent_r;
    end else if (cmd.shift && rv_r) begin
      ent_mem_r[shift_wa[ADDR_W-1:0]] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.status <= cmd.res_st;
      case (cmd.res_dat)
        DSEL_BEST: begin
          res_r.out_name_key <= best_r.name;
          res_r.out_book_key <= best_r.book;
          res_r.out_priority <= best_r.prio;
        end
        DSEL_HIT: begin
          res_r.out_name_key <= hit_ent_r.name;
          res_r.out_book_key <= hit_ent_r.book;
          res_r.out_priority <= hit_ent_r.prio;
        end
        default: begin
          res_r.out_name_key <= '0;
          res_r.out_book_key <= '0;
          res_r.out_priority <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pqkr_ctrl.sv
// Controller of the keyed-removal priority queue: sequences decode, scan,
// swap, shift and result transfer through command and status structs.
// Depends on pqkr_pkg.
`default_nettype none

module pqkr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire pqkr_pkg::stat_t  stat,
  output pqkr_pkg::cmd_t        cmd
);
  import pqkr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.res_st  = ST_OK;
    cmd.res_dat = DSEL_NONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.op)
          OP_ENQ: begin
            cmd.res_load = 1'b1;
            if (stat.full) begin
              cmd.res_st = ST_FULL;
            end else begin
              cmd.enq_wr = 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_DEQ: begin
            if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_st   = ST_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: state_nxt = S_SCAN;
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          case (stat.op)
            OP_DEQ: state_nxt = S_SWAP_A;
            OP_REM: begin
              if (stat.hit) begin
                cmd.shift_start = 1'b1;
                state_nxt       = S_SHIFT;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_st   = ST_NOT_FOUND;
                state_nxt    = S_DONE;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              if (stat.hit) begin
                cmd.res_dat = DSEL_HIT;
              end else begin
                cmd.res_st = ST_NOT_FOUND;
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_nxt  = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_b   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_dat  = DSEL_BEST;
        state_nxt    = S_DONE;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.scan_done) begin
          cmd.tail_dec = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for priority_queue_with_keyed_removal_top: a directed table, then random phases.
// The checker mirrors the queue slots, head and tail; it predicts each result that the directed table does not fix.
// Depends on pqkr_pkg and the RTL under hw/rtl.

module tb;
  import pqkr_pkg::*;

  localparam int RAND_PER_PHASE = 325;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 64;

  typedef struct packed {
    in_item_t    item;
    logic [4:0]  reps;
    logic        fixed;
    out_item_t   want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [31:0] slot_name [QUEUE_DEPTH];
  logic [31:0] slot_book [QUEUE_DEPTH];
  logic [1:0]  slot_prio [QUEUE_DEPTH];
  int          live_head;
  int          live_tail;

  out_item_t   pending_results [$];
  stim_row_t   dir_rows [$];
  int          fail_count   = 0;
  int          quiet_cycles = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  bit          valid_on     = 1'b0;

  priority_queue_with_keyed_removal_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t queue_apply(input in_item_t it);
    out_item_t   r;
    int          best;
    int          idx;
    int          i;
    logic [31:0] tn;
    logic [31:0] tb_;
    logic [1:0]  tp;
    r = '0;
    r.status = ST_OK;
    idx = -1;
    case (it.operation)
      OP_ENQ: begin
        if (live_tail >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_name[live_tail] = it.name_key;
          slot_book[live_tail] = it.book_key;
          slot_prio[live_tail] = it.priority_req;
          live_tail++;
        end
      end
      OP_DEQ: begin
        if (live_head >= live_tail) begin
          r.status = ST_EMPTY;
        end else begin
          best = live_head;
          for (i = live_head + 1; i < live_tail; i++)
            if (slot_prio[i] > slot_prio[best]) best = i;
          tn = slot_name[live_head];
          tb_ = slot_book[live_head];
          tp = slot_prio[live_head];
          slot_name[live_head] = slot_name[best];
          slot_book[live_head] = slot_book[best];
          slot_prio[live_head] = slot_prio[best];
          slot_name[best] = tn;
          slot_book[best] = tb_;
          slot_prio[best] = tp;
          r.out_name_key = slot_name[live_head];
          r.out_book_key = slot_book[live_head];
          r.out_priority = slot_prio[live_head];
          live_head++;
        end
      end
      OP_FIND: begin
        for (i = live_head; i < live_tail; i++)
          if (idx < 0 && slot_book[i] == it.book_key) idx = i;
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.out_name_key = slot_name[idx];
          r.out_book_key = slot_book[idx];
          r.out_priority = slot_prio[idx];
        end
      end
      default: begin
        for (i = live_head; i < live_tail; i++)
          if (idx < 0 && slot_name[i] == it.name_key && slot_book[i] == it.book_key) idx = i;
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = idx; i + 1 < live_tail; i++) begin
            slot_name[i] = slot_name[i + 1];
            slot_book[i] = slot_book[i + 1];
            slot_prio[i] = slot_prio[i + 1];
          end
          live_tail--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 7));
    else if (r < 95) return $urandom;
    else return 32'hFFFF_FFFF;
  endfunction

  task automatic add_row(input op_t op, input logic [31:0] name, input logic [31:0] book,
                         input logic [1:0] prio, input int reps, input bit fixed,
                         input status_t st, input logic [31:0] want_name,
                         input logic [31:0] want_book, input logic [1:0] want_prio);
    stim_row_t row;
    row.item.operation    = op;
    row.item.name_key     = name;
    row.item.book_key     = book;
    row.item.priority_req = prio;
    row.reps              = 5'(reps);
    row.fixed             = fixed;
    row.want.status       = st;
    row.want.out_name_key = want_name;
    row.want.out_book_key = want_book;
    row.want.out_priority = want_prio;
    dir_rows.push_back(row);
  endtask

  task automatic set_valid(input bit v);
    if (valid_on != v) begin
      in_valid <= v;
      valid_on = v;
    end
  endtask

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      set_valid(1'b0);
      @(posedge clk);
    end
    in_data <= item;
    set_valid(1'b1);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    set_valid(1'b0);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result transfer: status %0d name %h book %h prio %0d",
                   out_data.status, out_data.out_name_key, out_data.out_book_key,
                   out_data.out_priority);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.out_name_key !== want.out_name_key ||
            out_data.out_book_key !== want.out_book_key ||
            out_data.out_priority !== want.out_priority) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch exp/act: status %0d/%0d name %h/%h book %h/%h prio %0d/%0d",
                     want.status, out_data.status, want.out_name_key, out_data.out_name_key,
                     want.out_book_key, out_data.out_book_key, want.out_priority,
                     out_data.out_priority);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t  it;
    stim_row_t row;
    int        k;
    int        phase;
    int        n;
    int        pick;
    int        enq_w;
    int        slot;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    live_head = 0;
    live_tail = 0;

    add_row(OP_DEQ,  0, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
    add_row(OP_FIND, 0, 0, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_REM,  0, 0, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_ENQ,  0, 0, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  '1, '1, 3, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 0, '1, 0, 1, 1, ST_OK, '1, '1, 3);
    add_row(OP_FIND, '1, 0, 3, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_REM,  '1, 0, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_ENQ,  32'h100, 32'h200, 1, 14, 1, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  32'hA, 32'hB, 2, 1, 1, ST_FULL, 0, 0, 0);
    add_row(OP_FIND, 0, 32'h200, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(OP_REM,  32'h105, 32'h200, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  32'h55, 32'h66, 2, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  1, 1, 1, 1, 1, ST_FULL, 0, 0, 0);
    add_row(OP_DEQ,  0, 0, 0, 3, 0, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  2, 2, 2, 1, 1, ST_FULL, 0, 0, 0);
    add_row(OP_REM,  0, 0, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_ENQ,  3, 3, 3, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 0, 32'h1234_5678, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_REM,  3, 3, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 0, 3, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (k = 0; k < row.reps; k++) begin
        it = row.item;
        it.name_key = it.name_key + k;
        send_item(it);
        if (row.fixed) begin
          void'(queue_apply(it));
          pending_results.push_back(row.want);
        end else begin
          pending_results.push_back(queue_apply(it));
        end
      end
    end
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        enq_w = (((phase * RAND_PER_PHASE + n) / 150) % 2) ? 15 : 45;
        pick = $urandom_range(0, 99);
        it.priority_req = 2'($urandom_range(0, 3));
        it.name_key = pick_key();
        it.book_key = pick_key();
        if (pick < 3 && !(live_head >= 14 && live_head < live_tail)) begin
          it.operation = OP_DEQ;
        end else if (pick < 3 + enq_w) begin
          it.operation = OP_ENQ;
        end else begin
          it.operation = (pick < 3 + enq_w + (97 - enq_w) / 3) ? OP_FIND : OP_REM;
          if (live_tail > live_head && $urandom_range(0, 99) < 85) begin
            slot = $urandom_range(live_head, live_tail - 1);
            it.book_key = slot_book[slot];
            if ($urandom_range(0, 9) != 0) it.name_key = slot_name[slot];
          end
        end
        send_item(it);
        pending_results.push_back(queue_apply(it));
      end
      drain_results();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
